// File: src/s2wc_pkg.sv
package s2wc_pkg;

  localparam int MAX_KERNEL = 7;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int LINE_SLOTS = MAX_KERNEL - 1;
  localparam int COEF_COUNT = MAX_KERNEL * MAX_KERNEL;

  localparam int PIX_W  = 16;
  localparam int SUM_W  = 40;
  localparam int KW     = 3;
  localparam int DIM_W  = 11;
  localparam int POS_W  = 10;
  localparam int AGE_W  = $clog2(MAX_KERNEL);
  localparam int DW     = $clog2((MAX_KERNEL - 1) / 2 + 1);
  localparam int CIDX_W = $clog2(COEF_COUNT);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_PAD   = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_KERNEL = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_WIDTH  = 2'd2
  } reg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [MAX_KERNEL-1:0] col_vec_t;
  typedef pix_t [COEF_COUNT-1:0] coef_bank_t;

  // clamped frame geometry
  typedef struct packed {
    logic [KW-1:0]    kk;
    logic [DW-1:0]    reach;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] w;
  } geom_t;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic             frame_end;
    logic             rowstart;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } tag_t;

  typedef struct packed {
    logic adv;
    logic load;
    logic rowstart;
  } cell_ctrl_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    last;
    logic                    frame_end;
  } result_t;

endpackage

// File: src/s2wc_front.sv
module s2wc_front import s2wc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  geom_t               geom,
  input  logic                cfg_restart,
  input  logic                adv,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [1:0]          cmd,
  input  logic [CIDX_W-1:0]   coef_index,
  input  logic signed [PIX_W-1:0] value,
  output coef_bank_t          coefs,
  output logic                s2_valid,
  output tag_t                s2_tag,
  output col_vec_t            s2_col
);

  localparam int LW = LINE_SLOTS * PIX_W;

  logic [DIM_W-1:0] scan_row;
  logic [POS_W-1:0] scan_col;
  logic [DW-1:0]    fcnt;
  logic [POS_W-1:0] fcol, frow;

  logic accept, is_pos;
  logic in_img, col_last, row_ok, col_ok, frame_last, flush_go;
  logic [POS_W-1:0] out_r, out_c, h_last, w_last;
  pix_t sample;

  logic [LW-1:0] line_mem [MAX_WIDTH];
  logic [LW-1:0] rd_word, fwd_word, old_word, wr_word;
  logic          fwd_hit;

  logic             s1_valid, s1_flush, s1_pos;
  pix_t             s1_sample;
  logic [DIM_W-1:0] s1_row;
  logic [POS_W-1:0] s1_col;
  tag_t             s1_tag;
  col_vec_t         s1_colv;

  assign item_stall = !adv || (fcnt != '0);
  assign accept     = item_valid && !item_stall;
  assign is_pos     = accept && (cmd == CMD_PIXEL || cmd == CMD_PAD);

  assign in_img     = scan_row < geom.h;
  assign col_last   = {1'b0, scan_col} == geom.w - 1'b1;
  assign row_ok     = scan_row >= DIM_W'(geom.reach);
  assign col_ok     = scan_col >= POS_W'(geom.reach);
  assign frame_last = col_last && (scan_row == geom.h + DIM_W'(geom.reach) - 1'b1);
  assign flush_go   = col_last && row_ok && (geom.reach != '0);
  assign out_r      = POS_W'(scan_row - DIM_W'(geom.reach));
  assign out_c      = scan_col - POS_W'(geom.reach);
  assign h_last     = POS_W'(geom.h - 1'b1);
  assign w_last     = POS_W'(geom.w - 1'b1);
  assign sample     = (cmd == CMD_PIXEL && in_img) ? value : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row <= '0;
      scan_col <= '0;
      fcnt     <= '0;
      fwd_hit  <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      coefs    <= '0;
    end else begin
      if (accept && cmd == CMD_LOAD && coef_index < CIDX_W'(COEF_COUNT)) begin
        coefs[coef_index] <= value;
      end
      if (cfg_restart) begin
        scan_row <= '0;
        scan_col <= '0;
        fcnt     <= '0;
      end else if (is_pos) begin
        if (frame_last) begin
          scan_row <= '0;
          scan_col <= '0;
        end else if (col_last) begin
          scan_row <= scan_row + 1'b1;
          scan_col <= '0;
        end else begin
          scan_col <= scan_col + 1'b1;
        end
        if (flush_go) begin
          fcnt <= geom.reach;
        end
      end else if (adv && fcnt != '0) begin
        fcnt <= fcnt - 1'b1;
      end
      if (adv) begin
        s1_valid <= is_pos || (fcnt != '0);
        s2_valid <= s1_valid;
        fwd_hit  <= is_pos && s1_valid && s1_pos && (s1_col == scan_col);
      end
    end
  end

  // flush position of the right-edge centres
  always_ff @(posedge clk) begin
    if (is_pos && flush_go) begin
      fcol <= out_c + 1'b1;
      frow <= out_r;
    end else if (adv && fcnt != '0) begin
      fcol <= fcol + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (is_pos) begin
      rd_word <= line_mem[scan_col];
    end
    if (adv && s1_valid && s1_pos) begin
      line_mem[s1_col] <= wr_word;
    end
    if (adv) begin
      fwd_word <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (is_pos) begin
        s1_flush  <= 1'b0;
        s1_pos    <= 1'b1;
        s1_sample <= sample;
        s1_row    <= scan_row;
        s1_col    <= scan_col;
        s1_tag    <= '{emit: row_ok && col_ok, last: !flush_go,
                       frame_end: (out_r == h_last) && (out_c == w_last),
                       rowstart: scan_col == '0, row: out_r, col: out_c};
      end else begin
        s1_flush  <= 1'b1;
        s1_pos    <= 1'b0;
        s1_sample <= '0;
        s1_row    <= scan_row;
        s1_col    <= fcol;
        s1_tag    <= '{emit: 1'b1, last: fcnt == DW'(1),
                       frame_end: (frow == h_last) && (fcol == w_last),
                       rowstart: 1'b0, row: frow, col: fcol};
      end
      s2_col <= s1_colv;
      s2_tag <= s1_tag;
    end
  end

  // line word: slot 0 holds the previous row, each row pushes the rest down
  assign old_word = fwd_hit ? fwd_word : rd_word;
  assign wr_word  = {old_word[LW-PIX_W-1:0], s1_sample};

  for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_age
    pix_t raw;
    if (b == 0) begin : g_new
      assign raw = s1_sample;
    end else begin : g_old
      assign raw = old_word[(b-1)*PIX_W +: PIX_W];
    end
    // drop rows above the frame, rows outside the kernel and every row of a flush column
    assign s1_colv[b] = (!s1_flush && AGE_W'(b) < geom.kk && DIM_W'(b) <= s1_row) ? raw : '0;
  end

`ifndef SYNTH
  a_flush_issues: assert property (@(posedge clk) disable iff (rst)
    (fcnt != '0) && adv |=> s1_valid && s1_flush)
    else $error("flush slot did not issue a zero column");
  a_flush_bounded: assert property (@(posedge clk) disable iff (rst)
    fcnt <= geom.reach)
    else $error("flush count beyond kernel reach");
  a_scan_in_row: assert property (@(posedge clk) disable iff (rst)
    {1'b0, scan_col} < geom.w)
    else $error("scan column outside the image");
`endif

endmodule

// File: src/s2wc_cell.sv
module s2wc_cell import s2wc_pkg::*; (
  input  logic                    clk,
  input  logic [AGE_W-1:0]        age,
  input  logic [KW-1:0]           kk,
  input  coef_bank_t              coefs,
  input  col_vec_t                col,
  input  cell_ctrl_t              ctrl,
  input  logic signed [SUM_W-1:0] part_in,
  output logic signed [SUM_W-1:0] part_out
);

  localparam int PAIRS = (MAX_KERNEL + 1) / 2;
  localparam int TAPS  = 2 * PAIRS;

  logic signed [PIX_W-1:0]   coef_sel [TAPS];
  logic signed [PIX_W-1:0]   cpad     [TAPS];
  logic signed [2*PIX_W-1:0] prod     [TAPS];
  logic signed [2*PIX_W:0]   pair     [PAIRS];
  logic signed [SUM_W-1:0]   tap_next, tap_sum, part;

  function automatic logic [CIDX_W-1:0] slot(input logic [AGE_W-1:0] k,
                                              input logic [AGE_W-1:0] a,
                                              input logic [AGE_W-1:0] b);
    logic [CIDX_W-1:0] rowi, coli;
    rowi = CIDX_W'(k - 1'b1 - b);
    coli = CIDX_W'(k - 1'b1 - a);
    return CIDX_W'(rowi * CIDX_W'(k)) + coli;
  endfunction

  always_comb begin
    for (int b = 0; b < TAPS; b++) begin
      cpad[b] = '0;
    end
    for (int b = 0; b < MAX_KERNEL; b++) begin
      cpad[b] = col[b];
    end
  end

  // pick this column's coefficients for the current kernel size
  always_ff @(posedge clk) begin
    for (int b = 0; b < TAPS; b++) begin
      if (b < MAX_KERNEL && age < kk && AGE_W'(b) < kk) begin
        coef_sel[b] <= coefs[slot(kk, age, AGE_W'(b))];
      end else begin
        coef_sel[b] <= '0;
      end
    end
  end

  always_comb begin
    tap_next = '0;
    for (int i = 0; i < PAIRS; i++) begin
      tap_next = tap_next + SUM_W'(pair[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      for (int b = 0; b < TAPS; b++) begin
        prod[b] <= coef_sel[b] * cpad[b];
      end
      for (int i = 0; i < PAIRS; i++) begin
        pair[i] <= prod[2*i] + prod[2*i+1];
      end
      tap_sum <= tap_next;
    end
    // restart the chain at a row start so older columns drop out
    if (ctrl.load) begin
      part <= tap_sum + (ctrl.rowstart ? '0 : part_in);
    end
  end

  assign part_out = part;

endmodule

// File: src/s2wc_outq.sv
module s2wc_outq import s2wc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t din,
  output logic    full,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t dout
);

  result_t    entry [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       pop;

  assign result_valid = count != '0;
  assign full         = count == 2'd2;
  assign pop          = result_valid && !result_stall;
  assign dout         = entry[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= din;
    end
  end

endmodule

// File: src/same_size_2d_window_convolution.sv
// Same-size K x K window correlation over a raster pixel stream, zero padded
// at the image borders. Load coefficients (Q2.14, index row*K+col) with cmd 0,
// then send H*W pixels (cmd 1) followed by D = K-1-K/2 rows of pad items
// (cmd 2) to drain the bottom edge. The block takes one item per clock while
// the result queue has room; at the end of every row that produces output it
// also stalls while it shifts the D right-edge centres (D is 0 to 3) out
// through the window. After the line store read, a result passes the column
// alignment, product, pair-sum, column-sum and chain stages of the column
// cells and the result queue write. A two-entry result queue keeps the
// input side moving while a result waits. Any register write restarts the
// frame at row 0, column 0.
module same_size_2d_window_convolution import s2wc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic [1:0]              cmd,
  input  logic [CIDX_W-1:0]       coef_index,
  input  logic signed [PIX_W-1:0] value,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic signed [SUM_W-1:0] sum,
  output logic [POS_W-1:0]        out_row,
  output logic [POS_W-1:0]        out_col,
  output logic                    last,
  output logic                    frame_end
);

  logic [KW-1:0]    win_size;
  logic [DIM_W-1:0] image_height, image_width;
  logic [1:0]       reg_sel;
  logic             wr, restart;
  logic [KW-1:0]    kk;
  geom_t            geom;

  logic       adv, full;
  coef_bank_t coefs;
  logic       s2_valid, p_valid, q_valid, s_valid, r_valid;
  tag_t       s2_tag, p_tag, q_tag, s_tag, r_tag;
  col_vec_t   s2_col;
  cell_ctrl_t ctrl;
  logic signed [SUM_W-1:0] part [MAX_KERNEL+1];
  result_t    res_in, res_out;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr      = psel && penable && pwrite;
  assign restart = wr && (reg_sel == REG_KERNEL || reg_sel == REG_HEIGHT ||
                          reg_sel == REG_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      win_size     <= KW'(3);
      image_height <= DIM_W'(8);
      image_width  <= DIM_W'(8);
    end else if (wr) begin
      case (reg_sel)
        REG_KERNEL: win_size     <= pwdata[KW-1:0];
        REG_HEIGHT: image_height <= pwdata[DIM_W-1:0];
        REG_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_KERNEL: prdata = 32'(win_size);
      REG_HEIGHT: prdata = 32'(image_height);
      REG_WIDTH:  prdata = 32'(image_width);
      default:    prdata = '0;
    endcase
  end

  assign kk = (win_size == '0) ? KW'(1) : win_size;

  always_comb begin
    geom.kk    = kk;
    geom.reach = DW'((kk - 1'b1) - (kk >> 1));
    if (image_height < DIM_W'(kk)) begin
      geom.h = DIM_W'(kk);
    end else if (image_height > DIM_W'(MAX_HEIGHT)) begin
      geom.h = DIM_W'(MAX_HEIGHT);
    end else begin
      geom.h = image_height;
    end
    if (image_width < DIM_W'(kk)) begin
      geom.w = DIM_W'(kk);
    end else if (image_width > DIM_W'(MAX_WIDTH)) begin
      geom.w = DIM_W'(MAX_WIDTH);
    end else begin
      geom.w = image_width;
    end
  end

  assign adv = !full;

  s2wc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .geom        (geom),
    .cfg_restart (restart),
    .adv         (adv),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .cmd         (cmd),
    .coef_index  (coef_index),
    .value       (value),
    .coefs       (coefs),
    .s2_valid    (s2_valid),
    .s2_tag      (s2_tag),
    .s2_col      (s2_col)
  );

  // tags follow the cell stages
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      q_valid <= 1'b0;
      s_valid <= 1'b0;
      r_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= s2_valid;
      q_valid <= p_valid;
      s_valid <= q_valid;
      r_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_tag <= s2_tag;
      q_tag <= p_tag;
      s_tag <= q_tag;
      r_tag <= s_tag;
    end
  end

  assign ctrl.adv      = adv;
  assign ctrl.load     = adv && s_valid;
  assign ctrl.rowstart = s_tag.rowstart;

  assign part[MAX_KERNEL] = '0;

  for (genvar a = 0; a < MAX_KERNEL; a++) begin : g_cell
    s2wc_cell u_cell (
      .clk      (clk),
      .age      (AGE_W'(a)),
      .kk       (kk),
      .coefs    (coefs),
      .col      (s2_col),
      .ctrl     (ctrl),
      .part_in  (part[a+1]),
      .part_out (part[a])
    );
  end

  assign res_in = '{sum: part[0], row: r_tag.row, col: r_tag.col,
                    last: r_tag.last, frame_end: r_tag.frame_end};

  s2wc_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (adv && r_valid && r_tag.emit),
    .din          (res_in),
    .full         (full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .dout         (res_out)
  );

  assign sum       = res_out.sum;
  assign out_row   = res_out.row;
  assign out_col   = res_out.col;
  assign last      = res_out.last;
  assign frame_end = res_out.frame_end;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import s2wc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;

  class conv_scoreboard;
    int unsigned ksz, hgt, wid;
    int unsigned scan_r, scan_c;
    shortint coef[COEF_COUNT];
    shortint line_mem[LINE_SLOTS*MAX_WIDTH];
    shortint win[COEF_COUNT];
    result_t pending_q[$];
    int errors;
    int checked;

    function new();
      ksz = 3; hgt = 8; wid = 8;
      scan_r = 0; scan_c = 0;
      errors = 0; checked = 0;
      foreach (coef[i]) coef[i] = 0;
      foreach (win[i]) win[i] = 0;
      foreach (line_mem[i]) line_mem[i] = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void geometry(output int unsigned kk, output int unsigned d,
                           output int unsigned h, output int unsigned w);
      kk = clamp(ksz, 1, MAX_KERNEL);
      d = kk - 1 - kk / 2;
      h = clamp(hgt, kk, MAX_HEIGHT);
      w = clamp(wid, kk, MAX_WIDTH);
    endfunction

    function void write_reg(reg_idx_t a, logic [31:0] v);
      case (a)
        REG_KERNEL: ksz = v[KW-1:0];
        REG_HEIGHT: hgt = v[DIM_W-1:0];
        REG_WIDTH:  wid = v[DIM_W-1:0];
        default: return;
      endcase
      scan_r = 0;
      scan_c = 0;
    endfunction

    function void shift_in(int unsigned kk, shortint colv[MAX_KERNEL]);
      for (int k = 0; k < kk; k++) begin
        for (int m = 0; m + 1 < kk; m++) win[k*MAX_KERNEL+m] = win[k*MAX_KERNEL+m+1];
        win[k*MAX_KERNEL+kk-1] = colv[k];
      end
    endfunction

    function longint window_total(int unsigned kk, int unsigned h, int unsigned w,
                                  int unsigned rc, int unsigned cc);
      longint acc;
      int x, y, z;
      acc = 0;
      z = kk / 2;
      for (int k = 0; k < kk; k++) begin
        x = int'(rc) + k - z;
        if (x < 0 || x >= int'(h)) continue;
        for (int m = 0; m < kk; m++) begin
          y = int'(cc) + m - z;
          if (y < 0 || y >= int'(w)) continue;
          acc += longint'(coef[k*kk+m]) * longint'(win[k*MAX_KERNEL+m]);
        end
      end
      return acc;
    endfunction

    function result_t make_result(longint s, int unsigned rc, int unsigned cc,
                                  int unsigned h, int unsigned w);
      result_t e;
      e.sum = s[SUM_W-1:0];
      e.row = rc[POS_W-1:0];
      e.col = cc[POS_W-1:0];
      e.last = 1'b0;
      e.frame_end = (rc == h - 1) && (cc == w - 1);
      return e;
    endfunction

    // Predict the results of one accepted item.
    function void note_item(logic [1:0] c, logic [5:0] idx, logic signed [15:0] v);
      int unsigned kk, d, h, w, r, col;
      shortint s;
      shortint colv[MAX_KERNEL];
      shortint zc[MAX_KERNEL];
      result_t fresh[$];
      if (c == CMD_LOAD) begin
        if (idx < COEF_COUNT) coef[idx] = v;
        return;
      end
      if (c == CMD_NOP) return;
      geometry(kk, d, h, w);
      r = scan_r;
      col = scan_c;
      if (col >= w || r >= h + d) begin
        r = 0;
        col = 0;
      end
      s = (c == CMD_PIXEL && r < h) ? v : 16'sd0;
      foreach (colv[k]) colv[k] = 0;
      foreach (zc[k]) zc[k] = 0;
      for (int k = 0; k + 1 < kk; k++) colv[k] = line_mem[col*LINE_SLOTS+k];
      colv[kk-1] = s;
      for (int k = 0; k + 1 < kk; k++) line_mem[col*LINE_SLOTS+k] = colv[k+1];
      shift_in(kk, colv);
      if (r >= d && col >= d)
        fresh.push_back(make_result(window_total(kk, h, w, r - d, col - d),
                                    r - d, col - d, h, w));
      if (col == w - 1) begin
        for (int f = 1; f <= d; f++) begin
          shift_in(kk, zc);
          if (r >= d)
            fresh.push_back(make_result(window_total(kk, h, w, r - d, col - d + f),
                                        r - d, col - d + f, h, w));
        end
      end
      if (r == h - 1 + d && col == w - 1) begin
        scan_r = 0;
        scan_c = 0;
      end else if (col + 1 >= w) begin
        scan_r = r + 1;
        scan_c = 0;
      end else begin
        scan_r = r;
        scan_c = col + 1;
      end
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[i]) pending_q.push_back(fresh[i]);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(result_t got);
      result_t e;
      checked++;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result row %0d col %0d", got.row, got.col));
        return;
      end
      e = pending_q.pop_front();
      if (got.sum !== e.sum)
        report($sformatf("sum at (%0d,%0d): got %0d want %0d", e.row, e.col, got.sum, e.sum));
      if (got.row !== e.row) report($sformatf("out_row: got %0d want %0d", got.row, e.row));
      if (got.col !== e.col) report($sformatf("out_col: got %0d want %0d", got.col, e.col));
      if (got.last !== e.last)
        report($sformatf("last at (%0d,%0d): got %0b", e.row, e.col, got.last));
      if (got.frame_end !== e.frame_end)
        report($sformatf("frame_end at (%0d,%0d): got %0b", e.row, e.col, got.frame_end));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic item_valid, item_stall;
  logic [1:0] cmd;
  logic [CIDX_W-1:0] coef_index;
  logic signed [PIX_W-1:0] value;
  logic result_valid, result_stall;
  logic signed [SUM_W-1:0] sum;
  logic [POS_W-1:0] out_row, out_col;
  logic last, frame_end;

  conv_scoreboard sb = new();
  int idle_mode;
  int stall_mode;
  int items_sent;
  int settings_run;
  int quiet_cycles;
  int stall_left;

  always #2 clk = ~clk;

  same_size_2d_window_convolution u_top (.*);

  // Result side: in stall mode, hold off for a random time after each accepted result.
  always @(posedge clk) begin
    int wait_n;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_stall <= (stall_left > 1);
    end else if (result_valid && !result_stall) begin
      sb.check_result('{sum, out_row, out_col, last, frame_end});
      wait_n = stall_mode ? $urandom_range(0, 16) : 0;
      stall_left <= wait_n;
      result_stall <= (wait_n > 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(cmd_t c, logic [5:0] idx, logic [15:0] v);
    int gap;
    gap = idle_mode ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    cmd <= c;
    coef_index <= idx;
    value <= v;
    do @(posedge clk); while (item_stall);
    sb.note_item(c, idx, v);
    items_sent++;
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t a, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {a, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(a, v);
  endtask

  task automatic configure(logic [31:0] k, logic [31:0] h, logic [31:0] w);
    wait_drained();
    apb_write(REG_KERNEL, k);
    apb_write(REG_HEIGHT, h);
    apb_write(REG_WIDTH, w);
    settings_run++;
    idle_mode = $urandom_range(0, 2);
    stall_mode = $urandom_range(0, 2);
  endtask

  // Load the whole kernel, or only count random entries of a large one.
  task automatic load_kernel(int count);
    int unsigned kk, d, h, w;
    sb.geometry(kk, d, h, w);
    if (count >= int'(kk * kk)) begin
      for (int i = 0; i < int'(kk * kk); i++) send_item(CMD_LOAD, 6'(i), 16'($urandom));
    end else begin
      for (int i = 0; i < count; i++)
        send_item(CMD_LOAD, 6'($urandom_range(0, kk * kk - 1)), 16'($urandom));
    end
  endtask

  // Stream positions of the frame; max_pos bounds very large frames.
  task automatic stream_frame(int max_pos);
    int unsigned kk, d, h, w, r;
    int n, total;
    sb.geometry(kk, d, h, w);
    total = (h + d) * w;
    if (max_pos < total) total = max_pos;
    for (int p = 0; p < total; p++) begin
      r = p / w;
      n = $urandom_range(0, 19);
      if (n == 0) send_item(CMD_NOP, 6'($urandom), 16'($urandom));
      if (n == 1) send_item(CMD_LOAD, 6'($urandom_range(COEF_COUNT, 63)), 16'($urandom));
      if (r < h) send_item((n == 2) ? CMD_PAD : CMD_PIXEL, 6'($urandom), 16'($urandom));
      else send_item((n == 3) ? CMD_PIXEL : CMD_PAD, 6'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    item_valid <= 1'b0;
    cmd <= CMD_NOP;
    coef_index <= '0;
    value <= '0;
    idle_mode = 0;
    stall_mode = 0;
    items_sent = 0;
    settings_run = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on a 3x3 frame: extreme coefficients and pixels,
    // ignored commands, a pad inside the image and a pixel in the pad row.
    configure(3, 2, 3);
    idle_mode = 0;
    stall_mode = 0;
    send_item(CMD_LOAD, 6'd0, 16'h8000);
    send_item(CMD_LOAD, 6'd1, 16'h7fff);
    send_item(CMD_LOAD, 6'd2, 16'h4000);
    send_item(CMD_LOAD, 6'd3, 16'h7fff);
    send_item(CMD_LOAD, 6'd4, 16'h8000);
    send_item(CMD_LOAD, 6'd5, 16'hffff);
    send_item(CMD_LOAD, 6'd6, 16'h0001);
    send_item(CMD_LOAD, 6'd7, 16'h8000);
    send_item(CMD_LOAD, 6'd8, 16'h7fff);
    send_item(CMD_LOAD, 6'd63, 16'h1234);
    send_item(CMD_LOAD, 6'd49, 16'hffff);
    send_item(CMD_NOP, 6'h3f, 16'hffff);
    send_item(CMD_PIXEL, 6'd0, 16'h7fff);
    send_item(CMD_PIXEL, 6'd0, 16'h8000);
    send_item(CMD_PAD, 6'd0, 16'h7fff);
    send_item(CMD_PIXEL, 6'd0, 16'hffff);
    for (int p = 4; p < 9; p++) send_item(CMD_PIXEL, 6'd0, (p % 2) ? 16'h8000 : 16'h7fff);
    for (int p = 0; p < 3; p++) send_item((p % 2) ? CMD_PIXEL : CMD_PAD, 6'd0, 16'h7fff);

    // Largest sizes, partial frame only; the next write restarts mid-frame.
    configure(7, 2047, 2047); stream_frame(6);
    configure(7, 7, 7);   load_kernel(8); stream_frame(1 << 20);
    configure(2, 3, 0);   load_kernel(4); stream_frame(1 << 20);

    wait_drained();
    repeat (30) @(posedge clk);
    $display("Ran %0d items over %0d frame settings, checked %0d results",
             items_sent, settings_run, sb.checked);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/s2wc_pkg.sv
src/s2wc_front.sv
src/s2wc_cell.sv
src/s2wc_outq.sv
src/same_size_2d_window_convolution.sv
tb/sv/testbench.sv
